@@ sv/sparse_tile_bitmap_index_top_macros.svh @@
// Assertion shorthands for the tile directory block.
`ifndef SPARSE_TILE_BITMAP_INDEX_TOP_MACROS_SVH
`define SPARSE_TILE_BITMAP_INDEX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STBI_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STBI_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/stbi_pkg.sv @@
`timescale 1ns / 1ps

package stbi_pkg;

  // Grid and directory geometry
  localparam int GRID_ROWS    = 98;
  localparam int GRID_COLS    = 112;
  localparam int MAX_TILES    = 4096;
  localparam int CELL_COUNT   = GRID_ROWS * GRID_COLS;
  localparam int BITMAP_BYTES = (CELL_COUNT + 7) / 8;
  localparam int ENTRY_BYTES  = 8;

  // Bitmap storage: 64-bit words, one popcount per cycle
  localparam int WORD_BITS  = 64;
  localparam int WORD_BYTES = WORD_BITS / 8;
  localparam int LANE_W     = $clog2(WORD_BYTES);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int BM_WORDS   = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int BM_AW      = $clog2(BM_WORDS);
  localparam int LAST_WORD  = CELL_COUNT / WORD_BITS;
  localparam int LAST_BITS  = CELL_COUNT % WORD_BITS;

  // Entry storage: offset in the upper half, size in the lower half
  localparam int ENT_AW = $clog2(MAX_TILES);
  localparam int ENT_W  = 64;

  // Count widths
  localparam int CELL_W = 14;
  localparam int RANK_W = 14;
  localparam int CNT_W  = $clog2(WORD_BITS + 1);

  // Item modes
  localparam logic [1:0] MODE_BM_WR  = 2'd0;
  localparam logic [1:0] MODE_ENT_WR = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  typedef logic [WORD_BITS-1:0] bm_word_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // One step of the rank walk
  typedef struct packed {
    bm_word_t          word;
    logic [BM_AW-1:0]  widx;
    cell_t             tile_pos;
  } pop_req_t;

  typedef struct packed {
    cnt_t tot_cnt;
    cnt_t rank_cnt;
    logic cell_bit;
  } pop_res_t;

endpackage

@@ sv/stbi_if.sv @@
`timescale 1ns / 1ps

// Item channel
interface stbi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [10:0] byte_addr;
  logic [7:0]  byte_value;
  logic [11:0] entry_index;
  logic [31:0] entry_offset;
  logic [31:0] entry_size;
  logic [7:0]  row;
  logic [7:0]  col;

  modport source (output valid, mode, byte_addr, byte_value, entry_index,
                  entry_offset, entry_size, row, col, input ready);
  modport sink   (input valid, mode, byte_addr, byte_value, entry_index,
                  entry_offset, entry_size, row, col, output ready);
endinterface

// Lookup result channel
interface stbi_out_if;
  logic        valid;
  logic        ready;
  logic        present;
  logic        found;
  logic [13:0] rank;
  logic [31:0] tile_offset;
  logic [31:0] tile_size;
  logic        fits;
  logic [13:0] tile_total;

  modport source (output valid, present, found, rank, tile_offset, tile_size,
                  fits, tile_total, input ready);
  modport sink   (input valid, present, found, rank, tile_offset, tile_size,
                  fits, tile_total, output ready);
endinterface

// Archive size register write channel
interface stbi_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ sv/stbi_ram.sv @@
`timescale 1ns / 1ps

module stbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

@@ sv/stbi_popcnt.sv @@
`timescale 1ns / 1ps

module stbi_popcnt (
  input  stbi_pkg::pop_req_t req,
  output stbi_pkg::pop_res_t res
);

  import stbi_pkg::*;

  localparam bm_word_t LAST_MASK = (bm_word_t'(1) << LAST_BITS) - bm_word_t'(1);

  logic [BM_AW-1:0] cell_word;
  logic [BIT_W-1:0] cell_low;
  bm_word_t         rank_mask;
  bm_word_t         tot_mask;

  function automatic cnt_t count_ones(bm_word_t w);
    logic [3:0] byte_cnt [WORD_BYTES];
    cnt_t       sum;
    sum = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(w[b*8+k]);
      end
    end
    for (int b = 0; b < WORD_BYTES; b++) begin
      sum = sum + cnt_t'(byte_cnt[b]);
    end
    return sum;
  endfunction

  assign cell_word = BM_AW'(req.tile_pos >> BIT_W);
  assign cell_low  = req.tile_pos[BIT_W-1:0];

  // Select the bits that lie before the queried cell
  always_comb begin
    if (req.widx < cell_word) begin
      rank_mask = '1;
    end else if (req.widx == cell_word) begin
      rank_mask = (bm_word_t'(1) << cell_low) - bm_word_t'(1);
    end else begin
      rank_mask = '0;
    end
  end

  // Select the bits that lie inside the grid
  always_comb begin
    if (int'(req.widx) < LAST_WORD) begin
      tot_mask = '1;
    end else if (int'(req.widx) == LAST_WORD) begin
      tot_mask = LAST_MASK;
    end else begin
      tot_mask = '0;
    end
  end

  // Count both selections and pick the queried bit
  assign res.tot_cnt  = count_ones(req.word & tot_mask);
  assign res.rank_cnt = count_ones(req.word & rank_mask);
  assign res.cell_bit = (req.widx == cell_word) && req.word[cell_low];

endmodule

@@ sv/sparse_tile_bitmap_index_top.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------------
// cfg_ch   in   data: archive size in bytes (always ready)
// in_ch    in   mode, byte_addr, byte_value, entry_index, entry_offset,
//               entry_size, row, col
// out_ch   out  present, found, rank, tile_offset, tile_size, fits, tile_total
//
// Bitmap byte write: read-modify-write of a 64-bit word; entry writes end in S_IDLE.
// Lookup: walk over all 172 words through one shared 64-bit popcount unit, then
// S_CHECK, S_ENTRY if found, S_DONE; only S_DONE if the archive is too small.
// Reset clears the word valid bits at once, so the bitmap reads as zero with
// no clearing pass. A finished lookup waits in its own state while out_ch stalls.
`include "sparse_tile_bitmap_index_top_macros.svh"

module sparse_tile_bitmap_index_top (
  input logic      clk,
  input logic      rst_n,
  stbi_cfg_if.sink cfg_ch,
  stbi_in_if.sink  in_ch,
  stbi_out_if.source out_ch
);

  import stbi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BM_RMW,
    S_WALK,
    S_CHECK,
    S_ENTRY,
    S_DONE
  } state_t;

  localparam logic [BM_AW-1:0] BM_LAST   = BM_AW'(BM_WORDS - 1);
  localparam int               NEED_BASE = BITMAP_BYTES + ENTRY_BYTES;

  state_t state_r, state_nxt;

  logic [31:0]         arch_r, arch_nxt;
  logic [BM_WORDS-1:0] bm_vld_r, bm_vld_nxt;
  logic [BM_AW-1:0]    wcnt_r, wcnt_nxt;
  logic [LANE_W-1:0]   lane_r, lane_nxt;
  logic [7:0]          bval_r, bval_nxt;
  cell_t               cell_r, cell_nxt;
  logic                in_grid_r, in_grid_nxt;
  logic                bit_r, bit_nxt;
  rank_t               tot_r, tot_nxt;
  rank_t               rank_r, rank_nxt;
  logic                present_r, present_nxt;
  logic                found_r, found_nxt;
  logic                fits_r, fits_nxt;
  logic [31:0]         off_r, off_nxt;
  logic [31:0]         size_r, size_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_present_r, out_present_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_fits_r, out_fits_nxt;
  rank_t               out_rank_r, out_rank_nxt;
  rank_t               out_total_r, out_total_nxt;
  logic [31:0]         out_off_r, out_off_nxt;
  logic [31:0]         out_size_r, out_size_nxt;

  logic             in_acc;
  logic             bm_we;
  logic [BM_AW-1:0] bm_raddr;
  bm_word_t         bm_rdata;
  bm_word_t         bm_word;
  bm_word_t         bm_merged;
  logic             ent_we;
  logic [ENT_W-1:0] ent_rdata;
  logic [32:0]      need;
  logic [32:0]      span;
  pop_req_t         pop_req;
  pop_res_t         pop_res;

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign in_ch.ready   = (state_r == S_IDLE);
  assign cfg_ch.ready  = 1'b1;

  // Bitmap word store, unwritten words masked by their valid bit
  stbi_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BM_WORDS)
  ) u_bm_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (wcnt_r),
    .wdata (bm_merged),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  // Metadata entry store
  stbi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TILES)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ENT_AW'(in_ch.entry_index)),
    .wdata ({in_ch.entry_offset, in_ch.entry_size}),
    .raddr (ENT_AW'(rank_r)),
    .rdata (ent_rdata)
  );

  // Shared popcount unit for the rank walk
  assign pop_req.word     = bm_word;
  assign pop_req.widx     = wcnt_r;
  assign pop_req.tile_pos = cell_r;

  stbi_popcnt u_popcnt (
    .req (pop_req),
    .res (pop_res)
  );

  assign bm_word = bm_vld_r[wcnt_r] ? bm_rdata : '0;
  assign ent_we  = in_acc && (in_ch.mode == MODE_ENT_WR)
                   && (in_ch.entry_index < MAX_TILES);
  assign need    = (33'(rank_r) * 33'(ENTRY_BYTES)) + 33'(NEED_BASE);
  assign span    = 33'(ent_rdata[63:32]) + 33'(ent_rdata[31:0]);

  // Replace one byte lane of the stored word
  always_comb begin
    for (int l = 0; l < WORD_BYTES; l++) begin
      bm_merged[l*8 +: 8] = (LANE_W'(l) == lane_r) ? bval_r : bm_word[l*8 +: 8];
    end
  end

  // Drive the bitmap read address
  always_comb begin
    case (state_r)
      S_IDLE: begin
        bm_raddr = (in_ch.mode == MODE_BM_WR) ? BM_AW'(in_ch.byte_addr >> LANE_W) : '0;
      end
      S_WALK: begin
        bm_raddr = (wcnt_r == BM_LAST) ? '0 : wcnt_r + 1'b1;
      end
      default: begin
        bm_raddr = '0;
      end
    endcase
  end

  // Sequence byte writes and lookups
  always_comb begin
    state_nxt   = state_r;
    arch_nxt    = cfg_ch.valid ? cfg_ch.data : arch_r;
    bm_vld_nxt  = bm_vld_r;
    wcnt_nxt    = wcnt_r;
    lane_nxt    = lane_r;
    bval_nxt    = bval_r;
    cell_nxt    = cell_r;
    in_grid_nxt = in_grid_r;
    bit_nxt     = bit_r;
    tot_nxt     = tot_r;
    rank_nxt    = rank_r;
    present_nxt = present_r;
    found_nxt   = found_r;
    fits_nxt    = fits_r;
    off_nxt     = off_r;
    size_nxt    = size_r;
    bm_we       = 1'b0;

    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_present_nxt = out_present_r;
    out_found_nxt   = out_found_r;
    out_fits_nxt    = out_fits_r;
    out_rank_nxt    = out_rank_r;
    out_total_nxt   = out_total_r;
    out_off_nxt     = out_off_r;
    out_size_nxt    = out_size_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.mode == MODE_BM_WR) begin
            if (in_ch.byte_addr < BITMAP_BYTES) begin
              wcnt_nxt  = BM_AW'(in_ch.byte_addr >> LANE_W);
              lane_nxt  = in_ch.byte_addr[LANE_W-1:0];
              bval_nxt  = in_ch.byte_value;
              state_nxt = S_BM_RMW;
            end
          end else if (in_ch.mode == MODE_LOOKUP) begin
            present_nxt = 1'b0;
            found_nxt   = 1'b0;
            fits_nxt    = 1'b0;
            off_nxt     = '0;
            size_nxt    = '0;
            tot_nxt     = '0;
            rank_nxt    = '0;
            bit_nxt     = 1'b0;
            wcnt_nxt    = '0;
            in_grid_nxt = (in_ch.row < GRID_ROWS) && (in_ch.col < GRID_COLS);
            cell_nxt    = in_grid_nxt
                          ? cell_t'(cell_t'(in_ch.row) * cell_t'(GRID_COLS)
                                    + cell_t'(in_ch.col))
                          : '0;
            // Archive shorter than the bitmap: report all zero
            state_nxt   = (arch_r < BITMAP_BYTES) ? S_DONE : S_WALK;
          end
        end
      end
      S_BM_RMW: begin
        bm_we              = 1'b1;
        bm_vld_nxt[wcnt_r] = 1'b1;
        state_nxt          = S_IDLE;
      end
      S_WALK: begin
        tot_nxt  = tot_r + rank_t'(pop_res.tot_cnt);
        rank_nxt = rank_r + rank_t'(pop_res.rank_cnt);
        bit_nxt  = bit_r | pop_res.cell_bit;
        if (wcnt_r == BM_LAST) begin
          state_nxt = S_CHECK;
        end else begin
          wcnt_nxt = wcnt_r + 1'b1;
        end
      end
      S_CHECK: begin
        present_nxt = in_grid_r && bit_r;
        found_nxt   = present_nxt && (rank_r < rank_t'(MAX_TILES))
                      && ({1'b0, arch_r} >= need);
        state_nxt   = found_nxt ? S_ENTRY : S_DONE;
      end
      S_ENTRY: begin
        off_nxt   = ent_rdata[63:32];
        size_nxt  = ent_rdata[31:0];
        fits_nxt  = (span <= {1'b0, arch_r});
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = present_r;
          out_found_nxt   = found_r;
          out_fits_nxt    = fits_r;
          out_rank_nxt    = rank_r;
          out_total_nxt   = tot_r;
          out_off_nxt     = off_r;
          out_size_nxt    = size_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arch_r      <= '0;
      bm_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arch_r      <= arch_nxt;
      bm_vld_r    <= bm_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wcnt_r        <= wcnt_nxt;
    lane_r        <= lane_nxt;
    bval_r        <= bval_nxt;
    cell_r        <= cell_nxt;
    in_grid_r     <= in_grid_nxt;
    bit_r         <= bit_nxt;
    tot_r         <= tot_nxt;
    rank_r        <= rank_nxt;
    present_r     <= present_nxt;
    found_r       <= found_nxt;
    fits_r        <= fits_nxt;
    off_r         <= off_nxt;
    size_r        <= size_nxt;
    out_present_r <= out_present_nxt;
    out_found_r   <= out_found_nxt;
    out_fits_r    <= out_fits_nxt;
    out_rank_r    <= out_rank_nxt;
    out_total_r   <= out_total_nxt;
    out_off_r     <= out_off_nxt;
    out_size_r    <= out_size_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.present     = out_present_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.fits        = out_fits_r;
  assign out_ch.rank        = out_rank_r;
  assign out_ch.tile_total  = out_total_r;
  assign out_ch.tile_offset = out_off_r;
  assign out_ch.tile_size   = out_size_r;

  // Checks on the sequencer and the result flags
  `STBI_ASSERT_NEXT(a_lookup_busy, clk, rst_n, in_acc && (in_ch.mode == MODE_LOOKUP), !in_ch.ready, "input ready right after a lookup beat")
  `STBI_ASSERT_NOW(a_flag_chain, clk, rst_n, out_ch.valid, (!out_ch.fits || out_ch.found) && (!out_ch.found || out_ch.present), "result flags out of order")
  `STBI_ASSERT_NOW(a_rank_le_total, clk, rst_n, state_r == S_WALK, rank_r <= tot_r, "rank count passed total count")
  `STBI_ASSERT_NOW(a_absent_zero, clk, rst_n, out_ch.valid && !out_ch.found, (out_ch.tile_offset == 32'd0) && (out_ch.tile_size == 32'd0), "tile data on a miss")

endmodule
